/* rtl/bwsn_pkg.sv */
// ----------------------------------------------------------------------------
// bwsn_pkg
// Shared types and constants of the bone weight select and normalize block.
// ----------------------------------------------------------------------------
package bwsn_pkg;

    localparam int BONE_W        = 8;
    localparam int WEIGHT_W      = 16;
    localparam int SHARE_W       = 8;
    localparam int OUT_SLOTS     = 4;
    localparam int SHARE_SCALE   = 255;
    localparam int SLOT_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [BONE_W-1:0]   bone_index;
        logic [WEIGHT_W-1:0] influence;
        logic                vertex_end;
    } in_word_t;

    typedef struct packed {
        logic [BONE_W-1:0]  index_a;
        logic [BONE_W-1:0]  index_b;
        logic [BONE_W-1:0]  index_c;
        logic [BONE_W-1:0]  index_d;
        logic [SHARE_W-1:0] share_a;
        logic [SHARE_W-1:0] share_b;
        logic [SHARE_W-1:0] share_c;
        logic [SHARE_W-1:0] share_d;
    } out_word_t;

    // front to queue handshake
    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

endpackage

/* rtl/top4_bone_weight_select_normalize.sv */
// Throughput: one influence word per cycle at the input while the queue is
//   not full; the normalizer handles one vertex at a time (sum/load, 8 divider
//   steps, output load), so short vertices are paced by the divider through a
//   2-entry queue.
// Reset: rst_n async active low clears slots, queue and output valid.
// ----------------------------------------------------------------------------
// top4_bone_weight_select_normalize
// Keeps the strongest bone influences of a vertex and emits four bone
// indices with their weights scaled to floor(w*255/sum).
// ----------------------------------------------------------------------------
module top4_bone_weight_select_normalize #(
    parameter int SLOT_COUNT = bwsn_pkg::SLOT_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bwsn_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output bwsn_pkg::out_word_t out_word
);

    localparam int QW = SLOT_COUNT * (bwsn_pkg::BONE_W + bwsn_pkg::WEIGHT_W);

    bwsn_pkg::q_ctl_t q_ctl;
    logic [QW-1:0]    q_data;
    logic [QW-1:0]    head_data;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    bwsn_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_ctl    (q_ctl),
        .q_data   (q_data)
    );

    bwsn_queue #(.WIDTH(QW), .DEPTH(bwsn_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_ctl.push),
        .push_data (q_data),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    bwsn_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_data (head_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

/* rtl/bwsn_queue.sv */
// ----------------------------------------------------------------------------
// bwsn_queue
// Short register queue carrying finished vertex snapshots from the front
// end to the normalizer.
// ----------------------------------------------------------------------------
module bwsn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bwsn_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/bwsn_front.sv */
// ----------------------------------------------------------------------------
// bwsn_front
// Accepts influence words and keeps the slot set of the current vertex.
// On the last influence of a vertex the updated slots go to the queue and
// the slots are cleared.
// ----------------------------------------------------------------------------
module bwsn_front #(
    parameter int SLOT_COUNT = bwsn_pkg::SLOT_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bwsn_pkg::in_word_t         in_word,
    input  logic                       q_full,
    output bwsn_pkg::q_ctl_t           q_ctl,
    output logic [SLOT_COUNT*(bwsn_pkg::BONE_W+bwsn_pkg::WEIGHT_W)-1:0] q_data
);

    localparam int BW = bwsn_pkg::BONE_W;
    localparam int WW = bwsn_pkg::WEIGHT_W;
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int WOFS = SLOT_COUNT * BW;

    logic [BW-1:0] bone_reg   [SLOT_COUNT];
    logic [BW-1:0] bone_next  [SLOT_COUNT];
    logic [WW-1:0] weight_reg [SLOT_COUNT];
    logic [WW-1:0] weight_next[SLOT_COUNT];
    logic [BW-1:0] bone_upd   [SLOT_COUNT];
    logic [WW-1:0] weight_upd [SLOT_COUNT];
    logic          accept;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] pick;
    logic [WW-1:0] low;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (!free_found && weight_reg[k] == '0)
            begin
                free_found = 1'b1;
                free_idx   = IW'(k);
            end
        end
        // first slot holding the smallest weight
        low  = weight_reg[0];
        pick = '0;
        for (int k = 1; k < SLOT_COUNT; k++)
        begin
            if (weight_reg[k] < low)
            begin
                low  = weight_reg[k];
                pick = IW'(k);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            bone_upd[k]   = bone_reg[k];
            weight_upd[k] = weight_reg[k];
        end
        if (free_found)
        begin
            bone_upd[free_idx]   = in_word.bone_index;
            weight_upd[free_idx] = in_word.influence;
        end
        else if (in_word.influence > low)
        begin
            bone_upd[pick]   = in_word.bone_index;
            weight_upd[pick] = in_word.influence;
        end

        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            q_data[k*BW +: BW]        = bone_upd[k];
            q_data[WOFS + k*WW +: WW] = weight_upd[k];
            if (!accept)
            begin
                bone_next[k]   = bone_reg[k];
                weight_next[k] = weight_reg[k];
            end
            else if (in_word.vertex_end)
            begin
                bone_next[k]   = '0;
                weight_next[k] = '0;
            end
            else
            begin
                bone_next[k]   = bone_upd[k];
                weight_next[k] = weight_upd[k];
            end
        end
    end

    assign q_ctl.push = accept && in_word.vertex_end;
    assign q_ctl.full = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                bone_reg[k]   <= '0;
                weight_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                bone_reg[k]   <= bone_next[k];
                weight_reg[k] <= weight_next[k];
            end
        end
    end

endmodule

/* rtl/bwsn_back.sv */
// ----------------------------------------------------------------------------
// bwsn_back
// Normalizer: takes a vertex snapshot from the queue, sums the weights and
// runs one restoring divider lane per reported slot, one quotient bit per
// cycle, then loads the output register.
// ----------------------------------------------------------------------------
module bwsn_back #(
    parameter int SLOT_COUNT = bwsn_pkg::SLOT_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SLOT_COUNT*(bwsn_pkg::BONE_W+bwsn_pkg::WEIGHT_W)-1:0] head_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bwsn_pkg::out_word_t  out_word
);

    localparam int BW    = bwsn_pkg::BONE_W;
    localparam int WW    = bwsn_pkg::WEIGHT_W;
    localparam int SW    = bwsn_pkg::SHARE_W;
    localparam int OUTS  = bwsn_pkg::OUT_SLOTS;
    localparam int LANES = (SLOT_COUNT < OUTS) ? SLOT_COUNT : OUTS;
    localparam int SUM_W = WW + $clog2(SLOT_COUNT);
    localparam int RW    = SUM_W + SW;
    localparam int CNT_W = $clog2(SW);
    localparam int WOFS  = SLOT_COUNT * BW;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [RW-1:0]       rem_reg  [LANES];
    logic [RW-1:0]       rem_next [LANES];
    logic [SW-1:0]       quo_reg  [LANES];
    logic [SW-1:0]       quo_next [LANES];
    logic [BW-1:0]       bone_reg [LANES];
    logic [BW-1:0]       bone_next[LANES];
    logic                out_valid_reg, out_valid_next;
    bwsn_pkg::out_word_t out_word_reg, out_word_next;
    logic [SUM_W-1:0]    head_sum;
    logic [RW-1:0]       trial;
    logic [BW-1:0]       idx_sel  [OUTS];
    logic [SW-1:0]       shr_sel  [OUTS];
    logic                out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign trial     = RW'(sum_reg) << cnt_reg;

    always_comb
    begin
        head_sum = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            head_sum = head_sum + SUM_W'(head_data[WOFS + k*WW +: WW]);
        end
        for (int k = 0; k < OUTS; k++)
        begin
            idx_sel[k] = '0;
            shr_sel[k] = '0;
        end
        for (int k = 0; k < LANES; k++)
        begin
            idx_sel[k] = bone_reg[k];
            shr_sel[k] = (sum_reg == '0) ? '0 : quo_reg[k];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        for (int k = 0; k < LANES; k++)
        begin
            rem_next[k]  = rem_reg[k];
            quo_next[k]  = quo_reg[k];
            bone_next[k] = bone_reg[k];
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    sum_next = head_sum;
                    cnt_next = CNT_W'(SW - 1);
                    for (int k = 0; k < LANES; k++)
                    begin
                        // w * 255 as (w << 8) - w
                        rem_next[k]  = (RW'(head_data[WOFS + k*WW +: WW]) << SW)
                                     - RW'(head_data[WOFS + k*WW +: WW]);
                        quo_next[k]  = '0;
                        bone_next[k] = head_data[k*BW +: BW];
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    if (rem_reg[k] >= trial)
                    begin
                        rem_next[k]          = rem_reg[k] - trial;
                        quo_next[k][cnt_reg] = 1'b1;
                    end
                end
                if (cnt_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_word_next.index_a = idx_sel[0];
                    out_word_next.index_b = idx_sel[1];
                    out_word_next.index_c = idx_sel[2];
                    out_word_next.index_d = idx_sel[3];
                    out_word_next.share_a = shr_sel[0];
                    out_word_next.share_b = shr_sel[1];
                    out_word_next.share_c = shr_sel[2];
                    out_word_next.share_d = shr_sel[3];
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        sum_reg      <= sum_next;
        out_word_reg <= out_word_next;
        for (int k = 0; k < LANES; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            quo_reg[k]  <= quo_next[k];
            bone_reg[k] <= bone_next[k];
        end
    end

endmodule

/* rtl/bwsn_checker.sv */
// ----------------------------------------------------------------------------
// bwsn_checker
// Port-level checks of the bone weight select and normalize block.
// ----------------------------------------------------------------------------
module bwsn_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input bwsn_pkg::in_word_t  in_word,
    input logic                out_valid,
    input logic                out_ready,
    input bwsn_pkg::out_word_t out_word
);

    logic [9:0] share_total;
    logic       end_taken;
    logic [3:0] pending_reg, pending_next;

    assign share_total = 10'(out_word.share_a) + 10'(out_word.share_b)
                       + 10'(out_word.share_c) + 10'(out_word.share_d);
    assign end_taken   = in_valid && in_ready && in_word.vertex_end;

    // vertex ends taken but not yet delivered
    assign pending_next = pending_reg + 4'(end_taken) - 4'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // floors of shares of one sum never exceed the scale
    a_share_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> share_total <= 10'd255)
        else $error("normalized shares exceed 255 in total");

    // every result word belongs to an earlier vertex-end word
    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result word without a pending vertex end");

endmodule

bind top4_bone_weight_select_normalize bwsn_checker u_bwsn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the top-four bone weight selector. Streams vertex
// influences through the valid/ready input, keeps its own copy of the four
// weight slots to predict each vertex-end word, and compares every output
// word field by field under random idling and long back-pressure stretches.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOT_COUNT   = bwsn_pkg::SLOT_COUNT_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    bwsn_pkg::in_word_t  in_word  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    bwsn_pkg::out_word_t out_word;

    // predicted slot contents
    logic [bwsn_pkg::BONE_W-1:0]   held_bone   [SLOT_COUNT];
    logic [bwsn_pkg::WEIGHT_W-1:0] held_weight [SLOT_COUNT];

    bwsn_pkg::out_word_t expected_vertices [$];

    string field_name [8] = '{"index_a", "index_b", "index_c", "index_d",
                              "share_a", "share_b", "share_c", "share_d"};

    int error_count = 0;
    int cycle_count = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int rx_hold_req = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    top4_bone_weight_select_normalize #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // mostly zero, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [bwsn_pkg::WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return bwsn_pkg::WEIGHT_W'($urandom_range(1, 3));
            // ties on the minimum
            3, 4:    return bwsn_pkg::WEIGHT_W'(1000 * $urandom_range(1, 3));
            default: return bwsn_pkg::WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic bwsn_pkg::in_word_t make_word(input int bone, input int infl,
                                                     input bit last);
        bwsn_pkg::in_word_t w;
        w.bone_index = bwsn_pkg::BONE_W'(bone);
        w.influence  = bwsn_pkg::WEIGHT_W'(infl);
        w.vertex_end = last;
        return w;
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Slot update for one accepted word; queues the vertex result on vertex_end.
    function automatic void fold_influence(input bwsn_pkg::in_word_t w);
        int                            pick;
        bit                            placed;
        logic [bwsn_pkg::WEIGHT_W-1:0] low;
        int unsigned                   sum;
        int unsigned                   prod;
        logic [bwsn_pkg::BONE_W-1:0]   idx [bwsn_pkg::OUT_SLOTS];
        logic [bwsn_pkg::SHARE_W-1:0]  shr [bwsn_pkg::OUT_SLOTS];
        bwsn_pkg::out_word_t           vert;
        placed = 1'b0;
        for (int k = 0; k < SLOT_COUNT && !placed; k++)
        begin
            if (held_weight[k] == '0)
            begin
                held_bone[k]   = w.bone_index;
                held_weight[k] = w.influence;
                placed = 1'b1;
            end
        end
        if (!placed)
        begin
            pick = 0;
            low  = held_weight[0];
            for (int k = 1; k < SLOT_COUNT; k++)
            begin
                if (held_weight[k] < low)
                begin
                    low  = held_weight[k];
                    pick = k;
                end
            end
            if (w.influence > low)
            begin
                held_bone[pick]   = w.bone_index;
                held_weight[pick] = w.influence;
            end
        end
        if (!w.vertex_end)
            return;
        sum = 0;
        for (int k = 0; k < SLOT_COUNT; k++)
            sum += held_weight[k];
        for (int k = 0; k < bwsn_pkg::OUT_SLOTS; k++)
        begin
            idx[k] = '0;
            shr[k] = '0;
            if (k < SLOT_COUNT)
            begin
                idx[k] = held_bone[k];
                if (sum != 0)
                begin
                    prod   = held_weight[k] * bwsn_pkg::SHARE_SCALE;
                    shr[k] = bwsn_pkg::SHARE_W'(prod / sum);
                end
            end
        end
        vert = {idx[0], idx[1], idx[2], idx[3], shr[0], shr[1], shr[2], shr[3]};
        expected_vertices = {expected_vertices, vert};
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            held_bone[k]   = '0;
            held_weight[k] = '0;
        end
    endfunction

    function automatic void check_result(input bwsn_pkg::out_word_t got);
        bwsn_pkg::out_word_t exp;
        logic [63:0]         g;
        logic [63:0]         e;
        if (expected_vertices.size() == 0)
        begin
            flag_error($sformatf("unexpected output word %h", got));
            return;
        end
        exp = expected_vertices.pop_front();
        g = got;
        e = exp;
        for (int k = 0; k < 8; k++)
        begin
            if (g[63-8*k -: 8] !== e[63-8*k -: 8])
                flag_error($sformatf("%s expected %0d got %0d", field_name[k],
                                     e[63-8*k -: 8], g[63-8*k -: 8]));
        end
    endfunction

    // output side: checks each word and drives out_ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_word);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_influence(input bwsn_pkg::in_word_t w);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        fold_influence(w);
    endtask

    task automatic send_vertex(input int len);
        for (int i = 0; i < len; i++)
            send_influence(make_word($urandom_range(0, 255), pick_weight(), i == len - 1));
    endtask

    task automatic send_random_vertices(input int n_words, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words)
        begin
            len = $urandom_range(1, max_len);
            send_vertex(len);
            sent += len;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_influence(make_word(255, 65535, 1));
        // zero sum: shares are zero, stored bone still reported
        send_influence(make_word(7, 0, 1));
        // zero weights keep overwriting slot zero
        send_influence(make_word(3, 0, 0));
        send_influence(make_word(9, 0, 0));
        send_influence(make_word(12, 500, 1));
        // full slots: equal weight dropped, tie picks the lowest slot
        send_influence(make_word(1, 100, 0));
        send_influence(make_word(2, 300, 0));
        send_influence(make_word(3, 100, 0));
        send_influence(make_word(4, 200, 0));
        send_influence(make_word(5, 100, 0));
        send_influence(make_word(6, 150, 0));
        send_influence(make_word(7, 120, 0));
        send_influence(make_word(8, 65535, 1));
        for (int i = 0; i < 4; i++)
            send_influence(make_word(250 + i, 65535, i == 3));
        send_influence(make_word(0, 1, 0));
        send_influence(make_word(255, 65534, 1));
        // last slot holds the minimum and is replaced
        send_influence(make_word(10, 40000, 0));
        send_influence(make_word(11, 30000, 0));
        send_influence(make_word(12, 20000, 0));
        send_influence(make_word(13, 10000, 0));
        send_influence(make_word(14, 10001, 1));
        wait_for_results();
    endtask

    task automatic test_random_mix(input int n_words);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_random_vertices(n_words, 10);
    endtask

    // receiver holds off while short vertices keep coming, so the queue fills
    task automatic test_receiver_holdoff();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 300;
        send_random_vertices(80, 2);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++)
        begin
            send_random_vertices(25, 6);
            wait_for_results();
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_vertices(150, 8);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            held_bone[k]   = '0;
            held_weight[k] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(400);
        test_receiver_holdoff();
        test_drain_pause();
        test_back_to_back();
        test_random_mix(200);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_vertices.size() != 0)
            flag_error($sformatf("%0d vertex words never arrived", expected_vertices.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* top4_bone_weight_select_normalize.f */
rtl/bwsn_pkg.sv
rtl/bwsn_queue.sv
rtl/bwsn_front.sv
rtl/bwsn_back.sv
rtl/top4_bone_weight_select_normalize.sv
rtl/bwsn_checker.sv
verif/testbench.sv
